[src/wsd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types, codes and sample conversion for the wave stream decoder.
// ----------------------------------------------------------------------------
package wsd_pkg;

	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [1:0] KIND_FORMAT = 2'd0;
	localparam logic [1:0] KIND_FRAME  = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_SIGNATURE = 2'd1;
	localparam logic [1:0] ERR_FORMAT    = 2'd2;

	localparam logic [31:0] SIG_RIFF = 32'h4646_4952;
	localparam logic [31:0] SIG_WAVE = 32'h4556_4157;
	localparam logic [31:0] SIG_FMT  = 32'h2074_6d66;
	localparam logic [31:0] SIG_DATA = 32'h6174_6164;
	localparam logic [15:0] FLOAT_TAG = 16'h0003;

	typedef enum logic [3:0] {
		PH_IDLE, PH_RIFF_ID, PH_RIFF_SIZE, PH_WAVE_ID, PH_FMT_ID, PH_FMT_OSIZE,
		PH_FMT_SKIP, PH_FMT_SIZE, PH_FMT_BODY, PH_FMT_EXTRA, PH_DATA_ID,
		PH_DATA_OSIZE, PH_DATA_SKIP, PH_DATA_SIZE, PH_FRAMES, PH_DONE
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_req;
	} item_t;

	typedef struct packed {
		logic        [1:0]  kind;
		logic signed [15:0] left_sample;
		logic signed [15:0] right_sample;
		logic        [31:0] sample_rate;
		logic        [1:0]  channel_count;
		logic        [5:0]  sample_bits;
		logic               is_float;
		logic        [31:0] frame_count;
		logic               last_frame;
		logic        [1:0]  error_code;
	} result_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] left_raw;
		logic [31:0] right_raw;
		logic [5:0]  bits;
		logic [31:0] sample_rate;
		logic [1:0]  channel_count;
		logic [31:0] frame_count;
		logic        last_frame;
		logic [1:0]  error_code;
	} cmd_t;

	function automatic logic signed [15:0] conv_sample(input logic [31:0] raw,
		input logic [5:0] bits);
		logic signed [9:0]  v;
		logic        [7:0]  x;
		logic        [14:0] y;
		logic        [15:0] t;
		logic        [16:0] mag8;
		logic signed [24:0] x24;
		logic        [7:0]  e;
		logic        [23:0] mm;
		logic        [7:0]  sh;
		logic        [15:0] magf;
		logic signed [15:0] r;
		r = '0;
		case (bits)
			6'd8: begin
				v = $signed({1'b0, raw[7:0], 1'b0}) - 10'sd255;
				x = v[9] ? 8'(-v) : v[7:0];
				y = {x, 7'd0};
				t = ({1'b0, y} + 16'({8'd0, y[14:8]}) + 16'd1);
				mag8 = {2'b0, y} * 17'd0 + {2'b0, x, 7'd0} + 17'({9'd0, t[15:8]});
				if (v[9]) r = 16'(-$signed({1'b0, mag8[15:0]}));
				else if (mag8 > 17'd32767) r = 16'sd32767;
				else r = $signed(mag8[15:0]);
			end
			6'd16: r = $signed(raw[15:0]);
			6'd24: begin
				x24 = $signed({raw[23], raw[23:0]}) + (raw[23] ? 25'sd255 : 25'sd0);
				r = x24[23:8];
			end
			default: begin
				e  = raw[30:23];
				mm = {(e != 8'd0), raw[22:0]};
				sh = 8'd135 - e;
				if (e == 8'd255 && raw[22:0] != 23'd0) r = '0;
				else if (e >= 8'd127) r = raw[31] ? -16'sd32768 : 16'sd32767;
				else if (sh >= 8'd32) r = '0;
				else begin
					magf = 16'(mm >> sh[4:0]);
					r = raw[31] ? 16'(-$signed({1'b0, magf})) : $signed(magf);
				end
			end
		endcase
		return r;
	endfunction

endpackage

[src/wsd_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module wsd_fifo #(
	parameter type T = logic,
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     wdata,
	output logic full,
	input  logic pop,
	output T     rdata,
	output logic empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	T               mem_q [DEPTH];
	logic [AW-1:0]  wr_q, rd_q;
	logic [CW-1:0]  cnt_q;
	logic           do_wr, do_rd;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = push && !full;
	assign do_rd = pop && !empty;
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_rd) rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule

[src/wsd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_front
// Byte parser: walks the chunk structure, gathers samples, divides the data
// size by the frame size, and issues commands to the back end.
// ----------------------------------------------------------------------------
module wsd_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  wsd_pkg::item_t item,
	output logic           full,
	output logic           cmd_push,
	output wsd_pkg::cmd_t  cmd,
	input  logic           cmd_full
);
	import wsd_pkg::*;

	phase_t      phase_q, phase_n;
	logic [3:0]  idx_q, idx_n;
	logic [31:0] aw_q, aw_n, skip_q, skip_n, rate_q, rate_n, drem_q, drem_n, left_q, left_n;
	logic [15:0] fmt_q, fmt_n, ch_q, ch_n, bits_q, bits_n;
	logic        busy_q, pend_q, div_go;
	logic [4:0]  dcnt_q;
	logic [31:0] dq_q;
	logic [3:0]  drm_q, dvs_q, dvs_n;
	logic [4:0]  dtry;
	logic        acc, byte_emit;
	cmd_t        byte_cmd;

	assign full = busy_q || pend_q || cmd_full;
	assign acc  = push && !full;

	always_comb begin
		phase_t      ph;
		logic [4:0]  n;
		logic [2:0]  bps;
		logic [31:0] raw;
		logic        ok;
		phase_n = item.start_req ? PH_RIFF_ID : phase_q;
		idx_n   = item.start_req ? '0 : idx_q;
		aw_n    = item.start_req ? '0 : aw_q;
		skip_n  = item.start_req ? '0 : skip_q;
		fmt_n   = item.start_req ? '0 : fmt_q;
		ch_n    = item.start_req ? '0 : ch_q;
		rate_n  = item.start_req ? '0 : rate_q;
		bits_n  = item.start_req ? '0 : bits_q;
		drem_n  = item.start_req ? '0 : drem_q;
		left_n  = left_q;
		dvs_n   = dvs_q;
		div_go  = 1'b0;
		byte_emit = 1'b0;
		byte_cmd  = '0;
		ph  = phase_n;
		bps = bits_n[5:3];
		raw = '0;
		ok  = 1'b0;
		n   = 5'(idx_n) + 5'd1;
		if (ph != PH_IDLE && ph != PH_DONE) begin
			aw_n = {item.data_byte, aw_n[31:8]};
			case (ph)
				PH_FMT_SKIP, PH_FMT_EXTRA, PH_DATA_SKIP: begin
					skip_n = skip_n - 32'd1;
					if (skip_n == '0) phase_n = (ph == PH_FMT_SKIP) ? PH_FMT_ID : PH_DATA_ID;
				end
				PH_FMT_BODY: begin
					if (n == 5'd2) fmt_n = aw_n[31:16];
					else if (n == 5'd4) ch_n = aw_n[31:16];
					else if (n == 5'd8) rate_n = aw_n;
					else if (n == 5'd16) bits_n = aw_n[31:16];
					if (n < 5'd16) idx_n = n[3:0];
					else begin
						idx_n = '0;
						phase_n = (skip_n != '0) ? PH_FMT_EXTRA : PH_DATA_ID;
					end
				end
				PH_FRAMES: begin
					case (bps)
						3'd1:    raw = {24'd0, aw_n[31:24]};
						3'd2:    raw = {16'd0, aw_n[31:16]};
						3'd3:    raw = {8'd0, aw_n[31:8]};
						default: raw = aw_n;
					endcase
					// idx low bits count bytes of a sample, bit 2 marks the right channel
					if ({1'b0, idx_n[1:0]} + 3'd1 != bps) idx_n = idx_n + 4'd1;
					else if (ch_n == 16'd2 && !idx_n[2]) begin
						left_n = raw;
						idx_n  = 4'b0100;
					end else begin
						idx_n  = '0;
						drem_n = drem_n - 32'd1;
						byte_emit = 1'b1;
						byte_cmd.kind       = KIND_FRAME;
						byte_cmd.left_raw   = (ch_n == 16'd2) ? left_q : raw;
						byte_cmd.right_raw  = raw;
						byte_cmd.bits       = bits_n[5:0];
						byte_cmd.last_frame = (drem_n == '0);
						if (drem_n == '0) phase_n = PH_DONE;
					end
				end
				default: begin
					if (n < 5'd4) idx_n = n[3:0];
					else begin
						idx_n = '0;
						case (ph)
							PH_RIFF_ID, PH_WAVE_ID: begin
								if (aw_n != ((ph == PH_RIFF_ID) ? SIG_RIFF : SIG_WAVE)) begin
									byte_emit = 1'b1;
									byte_cmd.kind = KIND_ERROR;
									byte_cmd.error_code = ERR_SIGNATURE;
									phase_n = PH_IDLE;
								end else phase_n = (ph == PH_RIFF_ID) ? PH_RIFF_SIZE : PH_FMT_ID;
							end
							PH_RIFF_SIZE: phase_n = PH_WAVE_ID;
							PH_FMT_ID: phase_n = (aw_n == SIG_FMT) ? PH_FMT_SIZE : PH_FMT_OSIZE;
							PH_DATA_ID: phase_n = (aw_n == SIG_DATA) ? PH_DATA_SIZE : PH_DATA_OSIZE;
							PH_FMT_OSIZE, PH_DATA_OSIZE: begin
								skip_n = aw_n;
								if (aw_n != '0) phase_n = (ph == PH_FMT_OSIZE) ? PH_FMT_SKIP : PH_DATA_SKIP;
								else phase_n = (ph == PH_FMT_OSIZE) ? PH_FMT_ID : PH_DATA_ID;
							end
							PH_FMT_SIZE: begin
								skip_n = (aw_n > 32'd16) ? aw_n - 32'd16 : '0;
								phase_n = PH_FMT_BODY;
							end
							PH_DATA_SIZE: begin
								ok = (ch_n == 16'd1 || ch_n == 16'd2) &&
									(bits_n == 16'd8 || bits_n == 16'd16 || bits_n == 16'd24 ||
									(bits_n == 16'd32 && fmt_n == FLOAT_TAG));
								if (!ok) begin
									byte_emit = 1'b1;
									byte_cmd.kind = KIND_ERROR;
									byte_cmd.error_code = ERR_FORMAT;
									phase_n = PH_IDLE;
								end else begin
									// frame size in bytes: 1, 2, 3, 4, 6 or 8
									dvs_n = (ch_n == 16'd2) ? {bps, 1'b0} : {1'b0, bps};
									div_go = 1'b1;
									phase_n = PH_DONE;
								end
							end
							default: phase_n = PH_IDLE;
						endcase
					end
				end
			endcase
		end
	end

	assign dtry = {drm_q, dq_q[31]};

	always_comb begin
		cmd_push = 1'b0;
		cmd = byte_cmd;
		if (pend_q) begin
			cmd_push = !cmd_full;
			cmd = '0;
			cmd.kind          = KIND_FORMAT;
			cmd.bits          = bits_q[5:0];
			cmd.sample_rate   = rate_q;
			cmd.channel_count = ch_q[1:0];
			cmd.frame_count   = dq_q;
		end else if (acc) cmd_push = byte_emit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			idx_q   <= '0;
			aw_q    <= '0;
			skip_q  <= '0;
			fmt_q   <= '0;
			ch_q    <= '0;
			rate_q  <= '0;
			bits_q  <= '0;
			drem_q  <= '0;
			busy_q  <= 1'b0;
			pend_q  <= 1'b0;
			dcnt_q  <= '0;
		end else begin
			if (acc) begin
				phase_q <= phase_n;
				idx_q   <= idx_n;
				aw_q    <= aw_n;
				skip_q  <= skip_n;
				fmt_q   <= fmt_n;
				ch_q    <= ch_n;
				rate_q  <= rate_n;
				bits_q  <= bits_n;
				drem_q  <= drem_n;
				if (div_go) begin
					busy_q <= 1'b1;
					dcnt_q <= '0;
				end
			end
			if (busy_q) begin
				dcnt_q <= dcnt_q + 5'd1;
				if (dcnt_q == 5'd31) begin
					busy_q <= 1'b0;
					pend_q <= 1'b1;
				end
			end
			if (pend_q && !cmd_full) begin
				pend_q  <= 1'b0;
				drem_q  <= dq_q;
				phase_q <= (dq_q != '0) ? PH_FRAMES : PH_DONE;
			end
		end
	end

	// restoring divider, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (acc) left_q <= left_n;
		if (acc && div_go) begin
			dq_q  <= aw_n;
			drm_q <= '0;
			dvs_q <= dvs_n;
		end else if (busy_q) begin
			if (dtry >= {1'b0, dvs_q}) begin
				drm_q <= 4'(dtry - {1'b0, dvs_q});
				dq_q  <= {dq_q[30:0], 1'b1};
			end else begin
				drm_q <= dtry[3:0];
				dq_q  <= {dq_q[30:0], 1'b0};
			end
		end
	end
endmodule

[src/wsd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_back
// Execution side: converts commands into result items for the output queue.
// ----------------------------------------------------------------------------
module wsd_back (
	input  wsd_pkg::cmd_t    cmd,
	input  logic             cmd_empty,
	output logic             cmd_pop,
	output logic             res_push,
	output wsd_pkg::result_t res,
	input  logic             res_full
);
	import wsd_pkg::*;

	assign cmd_pop  = !cmd_empty && !res_full;
	assign res_push = cmd_pop;

	always_comb begin
		res = '0;
		res.kind = cmd.kind;
		case (cmd.kind)
			KIND_FORMAT: begin
				res.sample_rate   = cmd.sample_rate;
				res.channel_count = cmd.channel_count;
				res.sample_bits   = cmd.bits;
				res.is_float      = (cmd.bits == 6'd32);
				res.frame_count   = cmd.frame_count;
			end
			KIND_FRAME: begin
				res.left_sample  = conv_sample(cmd.left_raw, cmd.bits);
				res.right_sample = conv_sample(cmd.right_raw, cmd.bits);
				res.last_frame   = cmd.last_frame;
			end
			default: res.error_code = cmd.error_code;
		endcase
	end
endmodule

[src/wav_stream_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_stream_decoder
// RIFF/WAVE byte parser producing format, Q1.15 sample frame and error items.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the command queue has room, except at
// the data header, where a bit-serial divider (frame count = data size / frame
// size) holds full high, and it stays high until the format item is issued.
// A result is registered in the command queue, then in the result queue, before it reaches the output.
// Reset: arst_n clears the parser to idle and empties both queues; the
// parser waits for a byte with start_req.
module wav_stream_decoder #(
	parameter int QUEUE_DEPTH = wsd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  wsd_pkg::item_t   item,
	output logic             empty,
	input  logic             pop,
	output wsd_pkg::result_t result
);
	import wsd_pkg::*;

	// command queue between parser and converter
	logic    cmd_push, cmd_full, cmd_pop, cmd_empty;
	cmd_t    cmd_in, cmd_head;
	// result queue toward the consumer
	logic    res_push, res_full;
	result_t res_in;

	// parse bytes; hold full while dividing, until the format item is issued, or when the command queue fills
	wsd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.full     (full),
		.cmd_push (cmd_push),
		.cmd      (cmd_in),
		.cmd_full (cmd_full)
	);

	wsd_fifo #(.T(cmd_t), .DEPTH(QUEUE_DEPTH)) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_head),
		.empty  (cmd_empty)
	);

	// convert one command per cycle while the result queue has room
	wsd_back u_back (
		.cmd       (cmd_head),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res_push  (res_push),
		.res       (res_in),
		.res_full  (res_full)
	);

	// each result transfer leaves from this queue
	wsd_fifo #(.T(result_t), .DEPTH(QUEUE_DEPTH)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);
endmodule

[verif/wav_stream_decoder_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_stream_decoder_tb
// Self-checking bench for the wave stream decoder. A short table of bytes hits
// the signature errors and idle noise. Then come randomized wave files: junk
// chunks, long and short fmt chunks, unsupported formats, float specials,
// trailing bytes, truncated files and noise. A local parser predicts every
// result, and each result is checked field by field in order. Bursty input,
// a patterned output stall and one long output hold-off fill the queues.
// ----------------------------------------------------------------------------
module wav_stream_decoder_tb;
	import wsd_pkg::*;

	typedef struct {
		item_t   it;
		bit      typed;
		result_t res;
	} dir_row_t;

	logic    clk;
	logic    arst_n;
	logic    push;
	logic    full;
	item_t   item;
	logic    empty;
	logic    pop;
	result_t result;

	wav_stream_decoder i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	// Parser state of the local predictor
	phase_t      ph;
	logic [31:0] byte_idx;
	logic [31:0] shift_word;
	logic [31:0] skip_left;
	logic [15:0] fmt_tag;
	logic [15:0] chan_n;
	logic [31:0] rate_val;
	logic [15:0] bits_n;
	logic [31:0] frames_left;

	result_t  pending_q[$];
	item_t    file_q[$];
	dir_row_t dir_rows[$];
	int       errors = 0;
	int       burst_left = 0;
	int       cycle_cnt = 0;
	int       hold_left = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	task automatic flag(input string msg);
		errors++;
		$display("mismatch at %0t: %s", $time, msg);
	endtask

	task automatic clear_parser();
		ph = PH_IDLE;
		byte_idx = '0;
		shift_word = '0;
		skip_left = '0;
		fmt_tag = '0;
		chan_n = '0;
		rate_val = '0;
		bits_n = '0;
		frames_left = '0;
	endtask

	// Sample conversion to Q1.15: truncate toward zero, saturate
	function automatic int to_q15(input logic [31:0] raw);
		int v;
		logic [7:0]  ex;
		logic [23:0] man;
		case (bits_n)
			16'd8: begin
				v = ((int'(raw[7:0]) * 2 - 255) * 32768) / 255;
				if (v > 32767) v = 32767;
				if (v < -32768) v = -32768;
			end
			16'd16: v = $signed(raw[15:0]);
			16'd24: begin
				v = $signed(raw[23:0]);
				v = v / 256;
			end
			default: begin
				ex  = raw[30:23];
				man = {1'b0, raw[22:0]};
				if (ex == 8'd255 && man != 0) v = 0;
				else if (ex >= 8'd127) v = raw[31] ? -32768 : 32767;
				else begin
					if (ex != 0) man[23] = 1'b1;
					v = int'(man >> (135 - ex));
					if (raw[31]) v = -v;
				end
			end
		endcase
		return v;
	endfunction

	function automatic result_t err_result(input logic [1:0] code);
		result_t r;
		r = '0;
		r.kind = KIND_ERROR;
		r.error_code = code;
		return r;
	endfunction

	// Advance the predictor by one accepted byte
	task automatic predict_byte(input item_t it, output bit got, output result_t r);
		logic [31:0] n;
		logic [31:0] bps;
		logic [15:0] s;
		logic [63:0] fsize;
		bit          ok;
		got = 0;
		r = '0;
		if (it.start_req) begin
			clear_parser();
			ph = PH_RIFF_ID;
		end
		if (ph == PH_IDLE || ph == PH_DONE) return;
		shift_word = {it.data_byte, shift_word[31:8]};
		n = byte_idx + 1;
		case (ph)
			PH_FMT_SKIP, PH_FMT_EXTRA, PH_DATA_SKIP: begin
				skip_left--;
				if (skip_left == 0) ph = (ph == PH_FMT_SKIP) ? PH_FMT_ID : PH_DATA_ID;
				return;
			end
			PH_FMT_BODY: begin
				if (n == 2) fmt_tag = shift_word[31:16];
				else if (n == 4) chan_n = shift_word[31:16];
				else if (n == 8) rate_val = shift_word;
				else if (n == 16) bits_n = shift_word[31:16];
				if (n < 16) begin
					byte_idx = n;
					return;
				end
				byte_idx = 0;
				ph = (skip_left != 0) ? PH_FMT_EXTRA : PH_DATA_ID;
				return;
			end
			PH_FRAMES: begin
				bps = bits_n / 8;
				s = 16'(to_q15(shift_word >> (32 - 8 * bps)));
				if (n % bps != 0) begin
					byte_idx = n;
					return;
				end
				// hold the left sample of a stereo frame until the right one lands
				if (n == bps && chan_n == 2) begin
					skip_left = {16'd0, s};
					byte_idx = n;
					return;
				end
				byte_idx = 0;
				frames_left--;
				got = 1;
				r.kind = KIND_FRAME;
				r.left_sample = (chan_n == 2) ? skip_left[15:0] : s;
				r.right_sample = s;
				r.last_frame = (frames_left == 0);
				if (frames_left == 0) ph = PH_DONE;
				return;
			end
			default: ;
		endcase
		// the other phases take one little-endian word
		if (n < 4) begin
			byte_idx = n;
			return;
		end
		byte_idx = 0;
		case (ph)
			PH_RIFF_ID, PH_WAVE_ID: begin
				if (shift_word != ((ph == PH_RIFF_ID) ? SIG_RIFF : SIG_WAVE)) begin
					got = 1;
					r = err_result(ERR_SIGNATURE);
					ph = PH_IDLE;
				end else ph = (ph == PH_RIFF_ID) ? PH_RIFF_SIZE : PH_FMT_ID;
			end
			PH_RIFF_SIZE: ph = PH_WAVE_ID;
			PH_FMT_ID:  ph = (shift_word == SIG_FMT) ? PH_FMT_SIZE : PH_FMT_OSIZE;
			PH_DATA_ID: ph = (shift_word == SIG_DATA) ? PH_DATA_SIZE : PH_DATA_OSIZE;
			PH_FMT_OSIZE: begin
				skip_left = shift_word;
				ph = (skip_left != 0) ? PH_FMT_SKIP : PH_FMT_ID;
			end
			PH_DATA_OSIZE: begin
				skip_left = shift_word;
				ph = (skip_left != 0) ? PH_DATA_SKIP : PH_DATA_ID;
			end
			PH_FMT_SIZE: begin
				skip_left = (shift_word > 16) ? shift_word - 16 : 0;
				ph = PH_FMT_BODY;
			end
			PH_DATA_SIZE: begin
				ok = (chan_n == 1 || chan_n == 2) && (bits_n == 8 || bits_n == 16 ||
					bits_n == 24 || (bits_n == 32 && fmt_tag == FLOAT_TAG));
				got = 1;
				if (!ok) begin
					r = err_result(ERR_FORMAT);
					ph = PH_IDLE;
					return;
				end
				fsize = chan_n * (bits_n / 8);
				frames_left = 32'({32'd0, shift_word} / fsize);
				r.kind = KIND_FORMAT;
				r.sample_rate = rate_val;
				r.channel_count = chan_n[1:0];
				r.sample_bits = bits_n[5:0];
				r.is_float = (bits_n == 32);
				r.frame_count = frames_left;
				ph = (frames_left != 0) ? PH_FRAMES : PH_DONE;
			end
			default: ph = PH_IDLE;
		endcase
	endtask

	// Offer one byte in bursts; predict once the transfer happens
	task automatic send_byte(input item_t it, input bit typed, input result_t want);
		bit      got;
		result_t r;
		int      gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			repeat (gap) begin
				@(negedge clk);
				push <= 1'b0;
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		@(negedge clk);
		push <= 1'b1;
		item <= it;
		do @(posedge clk); while (full);
		predict_byte(it, got, r);
		if (typed) pending_q.push_back(want);
		else if (got) pending_q.push_back(r);
	endtask

	task automatic add_byte(input logic [7:0] b);
		item_t it;
		it.data_byte = b;
		it.start_req = 1'b0;
		file_q.push_back(it);
	endtask

	task automatic add_word(input logic [31:0] w, input int nbytes = 4);
		for (int i = 0; i < nbytes; i++) add_byte(w[8 * i +: 8]);
	endtask

	task automatic add_junk_chunks();
		int sz;
		repeat ($urandom_range(0, 2)) begin
			add_word($urandom);
			sz = $urandom_range(0, 6);
			add_word(sz);
			repeat (sz) add_byte($urandom);
		end
	endtask

	// Sample words biased toward extremes and float special values
	function automatic logic [31:0] pick_sample();
		case ($urandom_range(0, 15))
			0: return 32'h7F80_0000;
			1: return 32'hFF80_0000;
			2: return 32'h7FC0_0001;
			3: return 32'h0000_0001;
			4: return 32'hBF80_0000;
			5: return 32'h3F7F_FFFF;
			6: return 32'h0000_0000;
			7: return 32'hFFFF_FFFF;
			8: return 32'h8000_0000;
			9: return {$urandom_range(0, 1) == 1, 8'($urandom_range(100, 126)), 23'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	// Build one randomized wave file into file_q
	task automatic make_file();
		int          dice;
		int          fsz;
		logic [15:0] chans;
		logic [15:0] bits;
		int          bps;
		int          nfr;
		int          trail;
		logic [31:0] dsize;
		dice = $urandom_range(0, 99);
		file_q.delete();
		add_word(SIG_RIFF);
		add_word($urandom);
		add_word(SIG_WAVE);
		// corrupt one bit of either signature
		if (dice < 3) file_q[$urandom_range(0, 3)].data_byte ^= 8'(1 << $urandom_range(0, 7));
		else if (dice < 6)
			file_q[$urandom_range(8, 11)].data_byte ^= 8'(1 << $urandom_range(0, 7));
		file_q[0].start_req = 1'b1;
		add_junk_chunks();
		add_word(SIG_FMT);
		case ($urandom_range(0, 5))
			0: fsz = $urandom_range(0, 15);
			1: fsz = $urandom_range(17, 20);
			default: fsz = 16;
		endcase
		add_word(fsz);
		chans = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom_range(1, 2));
		case ($urandom_range(0, 19))
			0: bits = $urandom;
			1, 2, 3, 4: bits = 8;
			5, 6, 7, 8: bits = 16;
			9, 10, 11, 12: bits = 24;
			default: bits = 32;
		endcase
		add_word(($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'(bits == 32 ? 3 : 1), 2);
		add_word(chans, 2);
		add_word($urandom);
		add_word($urandom);
		add_word($urandom, 2);
		add_word(bits, 2);
		if (fsz > 16) repeat (fsz - 16) add_byte($urandom);
		add_junk_chunks();
		add_word(SIG_DATA);
		bps = (bits == 8 || bits == 16 || bits == 24 || bits == 32) ? bits / 8 : 1;
		nfr = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
		// no channels: no frame size to leave a partial frame of
		trail = (chans == 16'd0) ? 0 : $urandom_range(0, bps * int'(chans) - 1);
		dsize = nfr * bps * chans + trail;
		// huge data size: the next start cuts the file short
		if ($urandom_range(0, 19) == 0) dsize = 32'hFFFF_FFFF;
		add_word(dsize);
		repeat (nfr * chans) add_word(pick_sample(), bps);
		repeat (trail) add_byte($urandom);
		if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 5)) add_byte($urandom);
	endtask

	task automatic add_row(input logic [7:0] b, input bit st, input bit typed = 0,
		input logic [1:0] code = ERR_NONE);
		dir_row_t row;
		row.it.data_byte = b;
		row.it.start_req = st;
		row.typed = typed;
		row.res = err_result(code);
		dir_rows.push_back(row);
	endtask

	// Receiver: the stall pattern is redrawn from four modes; one long hold-off
	initial begin
		int mode;
		pop = 1'b0;
		mode = 0;
		forever begin
			@(negedge clk);
			cycle_cnt++;
			if (cycle_cnt % 200 == 0) mode = $urandom_range(0, 3);
			if (cycle_cnt == 1200) hold_left = 400;
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				case (mode)
					0: pop <= 1'b1;
					1: pop <= ($urandom_range(0, 1) == 1);
					2: pop <= ($urandom_range(0, 3) == 0);
					default: pop <= (cycle_cnt % 5 < 3);
				endcase
			end
		end
	end

	// Check every result transfer against the oldest expectation
	always @(posedge clk) begin
		result_t want;
		if (arst_n && pop && !empty) begin
			if (pending_q.size() == 0) flag("result with nothing expected");
			else begin
				want = pending_q.pop_front();
				if (result.kind !== want.kind)
					flag($sformatf("kind %0d, want %0d", result.kind, want.kind));
				if (result.left_sample !== want.left_sample)
					flag($sformatf("left %0d, want %0d", result.left_sample, want.left_sample));
				if (result.right_sample !== want.right_sample)
					flag($sformatf("right %0d, want %0d", result.right_sample, want.right_sample));
				if (result.sample_rate !== want.sample_rate)
					flag($sformatf("rate %0d, want %0d", result.sample_rate, want.sample_rate));
				if (result.channel_count !== want.channel_count)
					flag($sformatf("channels %0d, want %0d", result.channel_count,
						want.channel_count));
				if (result.sample_bits !== want.sample_bits)
					flag($sformatf("bits %0d, want %0d", result.sample_bits, want.sample_bits));
				if (result.is_float !== want.is_float)
					flag($sformatf("float %0b, want %0b", result.is_float, want.is_float));
				if (result.frame_count !== want.frame_count)
					flag($sformatf("frames %0d, want %0d", result.frame_count, want.frame_count));
				if (result.last_frame !== want.last_frame)
					flag($sformatf("last %0b, want %0b", result.last_frame, want.last_frame));
				if (result.error_code !== want.error_code)
					flag($sformatf("error %0d, want %0d", result.error_code, want.error_code));
			end
		end
	end

	initial begin
		int      sent;
		int      wait_cnt;
		result_t none;
		none = '0;
		arst_n = 1'b0;
		push = 1'b0;
		item = '0;
		clear_parser();
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: bad RIFF, idle noise, bad WAVE, noise after the error
		add_row("X", 1'b1);
		add_row("I", 1'b0);
		add_row("F", 1'b0);
		add_row("F", 1'b0, 1'b1, ERR_SIGNATURE);
		add_row(8'h00, 1'b0);
		add_row("R", 1'b1);
		add_row("I", 1'b0);
		add_row("F", 1'b0);
		add_row("F", 1'b0);
		add_row(8'h00, 1'b0);
		add_row(8'hFF, 1'b0);
		add_row(8'h00, 1'b0);
		add_row(8'hFF, 1'b0);
		add_row("W", 1'b0);
		add_row("A", 1'b0);
		add_row("V", 1'b0);
		add_row("X", 1'b0, 1'b1, ERR_SIGNATURE);
		add_row(8'hFF, 1'b0);
		add_row(8'h55, 1'b0);
		foreach (dir_rows[i]) send_byte(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].res);

		// Random files
		sent = 0;
		while (sent < 1700) begin
			make_file();
			foreach (file_q[i]) send_byte(file_q[i], 1'b0, none);
			sent += file_q.size();
		end
		@(negedge clk);
		push <= 1'b0;

		// Drain, then let the pipeline settle
		wait_cnt = 0;
		while (pending_q.size() != 0 && wait_cnt < 100000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (50) @(posedge clk);
		if (errors == 0 && pending_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
